// ===== rtl/mfbp_pkg.sv =====
// Package for the MSB-first bit packer: field widths, item codes,
// derived sizes of the packing word and the result buffer, shared structs.
// No dependencies.
package mfbp_pkg;

	localparam int MAX_FIELD_BITS = 32;

	localparam int COUNT_W = 6;
	localparam int DATA_W  = 32;
	localparam int FILL_W  = 2;
	localparam int BYTE_W  = 8;
	localparam int FREE_W  = 4;

	// packing word: partial byte plus the widest field, rounded up to bytes
	localparam int ACC_BYTES = (MAX_FIELD_BITS + 15) / 8;
	localparam int ACC_W     = ACC_BYTES * 8;
	localparam int SH_W      = $clog2(ACC_W + 1);
	localparam int IDX_W     = $clog2(ACC_BYTES);

	// most bytes one item can complete
	localparam int MAX_BYTES = (MAX_FIELD_BITS + 7) / 8;
	localparam int RES_W     = $clog2(MAX_BYTES + 1);

	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_FLUSH = 1'b1;

	localparam logic [FILL_W-1:0] FILL_ZERO = 2'd0;
	localparam logic [FILL_W-1:0] FILL_ONE  = 2'd1;
	localparam logic [FILL_W-1:0] FILL_DROP = 2'd2;

	localparam logic [BYTE_W-1:0] BYTE_MASK  = 8'hFF;
	localparam logic [FREE_W-1:0] EMPTY_FREE = 4'd8;

	typedef struct packed {
		logic [BYTE_W-1:0] pending;
		logic [FREE_W-1:0] free;
	} pack_state_t;

	typedef struct packed {
		logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes;
		logic [RES_W-1:0]                 count;
		pack_state_t                      next;
	} pack_res_t;

endpackage

// ===== rtl/mfbp_in_if.sv =====
// Input item channel of the MSB-first bit packer: valid/ready plus item fields.
// Depends on mfbp_pkg.
interface mfbp_in_if;
	logic                         valid;
	logic                         ready;
	logic                         kind;
	logic [mfbp_pkg::COUNT_W-1:0] bit_count;
	logic [mfbp_pkg::DATA_W-1:0]  bit_data;
	logic [mfbp_pkg::FILL_W-1:0]  fill_mode;

	modport source (output valid, kind, bit_count, bit_data, fill_mode, input ready);
	modport sink   (input valid, kind, bit_count, bit_data, fill_mode, output ready);
endinterface

// ===== rtl/mfbp_out_if.sv =====
// Output byte channel of the MSB-first bit packer: valid/ready plus byte and last flag.
// Depends on mfbp_pkg.
interface mfbp_out_if;
	logic                        valid;
	logic                        ready;
	logic [mfbp_pkg::BYTE_W-1:0] out_byte;
	logic                        last;

	modport source (output valid, out_byte, last, input ready);
	modport sink   (input valid, out_byte, last, output ready);
endinterface

// ===== rtl/mfbp_core.sv =====
// Combinational packing step: merges one item into the partial byte and
// returns the completed bytes and the next partial-byte state. Depends on mfbp_pkg.
module mfbp_core (
	input  logic                         kind,
	input  logic [mfbp_pkg::COUNT_W-1:0] bit_count,
	input  logic [mfbp_pkg::DATA_W-1:0]  bit_data,
	input  logic [mfbp_pkg::FILL_W-1:0]  fill_mode,
	input  mfbp_pkg::pack_state_t        st,
	output mfbp_pkg::pack_res_t          res
);
	import mfbp_pkg::*;

	localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(MAX_FIELD_BITS);

	logic [FREE_W-1:0]  used;
	logic [COUNT_W-1:0] cnt_sat;
	logic [ACC_W-1:0]   data_m;
	logic [SH_W-1:0]    total;
	logic [ACC_W-1:0]   acc;
	logic [BYTE_W-1:0]  acc_bytes [ACC_BYTES];
	logic [IDX_W-1:0]   done_idx;
	logic [BYTE_W-1:0]  flush_byte;

	assign used    = EMPTY_FREE - st.free;
	assign cnt_sat = (bit_count > MAX_CNT) ? MAX_CNT : bit_count;
	assign data_m  = ACC_W'(bit_data) & ~({ACC_W{1'b1}} << cnt_sat);
	assign total   = SH_W'(used) + SH_W'(cnt_sat);

	// left-align the stream: held bits on top, field right behind them
	assign acc = {st.pending, {(ACC_W-BYTE_W){1'b0}}}
		| (data_m << (SH_W'(ACC_W) - total));

	for (genvar k = 0; k < ACC_BYTES; k++) begin : g_split
		assign acc_bytes[k] = acc[ACC_W-1-8*k -: 8];
	end

	assign done_idx = IDX_W'(total[SH_W-1:3]);

	assign flush_byte = (fill_mode == FILL_ZERO) ? st.pending
		: (st.pending | ~(BYTE_MASK << st.free));

	always_comb begin
		for (int k = 0; k < MAX_BYTES; k++) begin
			res.bytes[k] = acc_bytes[k];
		end
		if (kind == KIND_FLUSH) begin
			res.bytes[0]     = flush_byte;
			res.count        = (st.free != EMPTY_FREE && fill_mode != FILL_DROP)
				? RES_W'(1) : '0;
			res.next.pending = '0;
			res.next.free    = EMPTY_FREE;
		end else begin
			// a zero count or a short field leaves total below a byte: nothing out
			res.count        = RES_W'(total[SH_W-1:3]);
			res.next.pending = acc_bytes[done_idx];
			res.next.free    = EMPTY_FREE - FREE_W'(total[2:0]);
		end
	end

endmodule

// ===== rtl/msb_first_bit_packer.sv =====
// Top level of the MSB-first bit packer: input register, packing step, byte buffer.
// Depends on mfbp_pkg, mfbp_in_if, mfbp_out_if and mfbp_core.
//
//   channel  dir  carries                                   one transfer is
//   item     in   kind, bit_count, bit_data, fill_mode      one write or flush
//   result   out  out_byte, last                            one packed byte
//
// An item is registered, then packed into a buffer of up to MAX_BYTES
// bytes, which drains one byte per cycle while result is ready. An item that
// completes n bytes occupies the buffer until its last byte is taken, so a
// 32-bit write can complete up to 4 bytes; items with no bytes go at one a cycle.
// The next item is taken while the buffer still drains. Reset empties the
// partial byte and drops all buffered bytes. A stalled result holds everything.
module msb_first_bit_packer (
	input logic        clk,
	input logic        arst_n,
	mfbp_in_if.sink    item,
	mfbp_out_if.source result
);
	import mfbp_pkg::*;

	logic               valid_s1;
	logic               kind_s1;
	logic [COUNT_W-1:0] bit_count_s1;
	logic [DATA_W-1:0]  bit_data_s1;
	logic [FILL_W-1:0]  fill_mode_s1;

	pack_state_t        state_q;
	pack_res_t          res;

	logic [BYTE_W-1:0]  bytes_q [MAX_BYTES];
	logic [RES_W-1:0]   cnt_q;

	logic               pop;
	logic               buf_free;
	logic               load;

	assign pop      = result.valid && result.ready;
	assign buf_free = (cnt_q == '0) || (cnt_q == RES_W'(1) && result.ready);
	assign load     = valid_s1 && buf_free;

	assign item.ready      = !valid_s1 || buf_free;
	assign result.valid    = (cnt_q != '0);
	assign result.out_byte = bytes_q[0];
	assign result.last     = (cnt_q == RES_W'(1));

	mfbp_core u_core (
		.kind      (kind_s1),
		.bit_count (bit_count_s1),
		.bit_data  (bit_data_s1),
		.fill_mode (fill_mode_s1),
		.st        (state_q),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1        <= 1'b0;
			cnt_q           <= '0;
			state_q.pending <= '0;
			state_q.free    <= EMPTY_FREE;
		end else begin
			if (item.ready) begin
				valid_s1 <= item.valid;
			end
			if (load) begin
				cnt_q   <= res.count;
				state_q <= res.next;
			end else if (pop) begin
				cnt_q <= cnt_q - RES_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			kind_s1      <= item.kind;
			bit_count_s1 <= item.bit_count;
			bit_data_s1  <= item.bit_data;
			fill_mode_s1 <= item.fill_mode;
		end
		if (load) begin
			for (int k = 0; k < MAX_BYTES; k++) begin
				bytes_q[k] <= res.bytes[k];
			end
		end else if (pop) begin
			// advance the next byte to the head
			for (int k = 0; k < MAX_BYTES - 1; k++) begin
				bytes_q[k] <= bytes_q[k+1];
			end
		end
	end

endmodule
